@@ hw/rtl/sbms_pkg.sv @@
// ----------------------------------------------------------------------------
// sbms_pkg: shared types and codes for the shared-buffer multi-stack
// Holds the beat layouts of both channels, the operation and status codes,
// and the command group that the sequencer sends to the free-list unit.
// ----------------------------------------------------------------------------
package sbms_pkg;

    // Operation codes carried in the kind field.
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // One input beat.
    typedef struct packed {
        logic        kind;
        logic [1:0]  stack_select;
        logic [31:0] push_value;
    } in_beat_t;

    // One result beat.
    typedef struct packed {
        logic [31:0] pop_value;
        status_t     status;
    } out_beat_t;

    // Commands from the sequencer to the free list.
    typedef struct packed {
        logic take;   // a push consumes the slot at the head
        logic give;   // a pop returns a slot at the tail
    } fifo_cmd_t;

endpackage

@@ hw/rtl/sbms_node_mem.sv @@
// ----------------------------------------------------------------------------
// sbms_node_mem: node buffer shared by all stacks
// Each node holds a data word and a link to the node below it. One write
// port and one registered read port.
// ----------------------------------------------------------------------------
module sbms_node_mem #(
    parameter int SLOTS      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          rd_en,
    input  logic [$clog2(SLOTS)-1:0]      rd_addr,
    input  logic                          wr_en,
    input  logic [$clog2(SLOTS)-1:0]      wr_addr,
    input  logic [DATA_WIDTH-1:0]         wr_value,
    input  logic [$clog2(SLOTS+1)-1:0]    wr_link,
    output logic [DATA_WIDTH-1:0]         rd_value,
    output logic [$clog2(SLOTS+1)-1:0]    rd_link
);

    localparam int PW = $clog2(SLOTS + 1);

    logic [DATA_WIDTH-1:0] value_mem [SLOTS];
    logic [PW-1:0]         link_mem  [SLOTS];
    logic [DATA_WIDTH-1:0] rd_value_reg;
    logic [PW-1:0]         rd_link_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            value_mem[wr_addr] <= wr_value;
            link_mem[wr_addr]  <= wr_link;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_value_reg <= value_mem[rd_addr];
            rd_link_reg  <= link_mem[rd_addr];
        end
    end

    assign rd_value = rd_value_reg;
    assign rd_link  = rd_link_reg;

endmodule

@@ hw/rtl/sbms_free_fifo.sv @@
// ----------------------------------------------------------------------------
// sbms_free_fifo: circular free list of buffer slots
// Keeps head, tail and count, and one pointer-advance unit shared by the
// head and the tail. Entries that were never written read as their own
// position, which gives the in-order reset contents without a clearing pass.
// ----------------------------------------------------------------------------
module sbms_free_fifo #(
    parameter int SLOTS = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      rd_en,
    input  sbms_pkg::fifo_cmd_t       cmd,
    input  logic [$clog2(SLOTS)-1:0]  give_slot,
    output logic [$clog2(SLOTS)-1:0]  head_slot,
    output logic                      empty
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [AW-1:0] slot_mem [SLOTS];
    logic [AW-1:0] rd_reg;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          wrapped_reg, wrapped_next;
    logic [AW-1:0] adv_src;
    logic [AW-1:0] adv_pos;
    logic          head_written;

    // Storage: the tail is written on a pop, the head is read on accept.
    always_ff @(posedge aclk) begin
        if (cmd.give) begin
            slot_mem[tail_reg] <= give_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_reg <= slot_mem[head_reg];
        end
    end

    // Shared pointer-advance unit; only one pointer moves per operation.
    assign adv_src = cmd.take ? head_reg : tail_reg;
    assign adv_pos = (adv_src == AW'(SLOTS - 1)) ? '0 : adv_src + AW'(1);

    // Pointer, count and fill-mark updates.
    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        wrapped_next = wrapped_reg;
        if (cmd.take) begin
            head_next  = adv_pos;
            count_next = count_reg - CW'(1);
        end
        if (cmd.give) begin
            tail_next = adv_pos;
            if (tail_reg == AW'(SLOTS - 1)) begin
                wrapped_next = 1'b1;
            end
            if (count_reg < CW'(SLOTS)) begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= CW'(SLOTS);
            wrapped_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            wrapped_reg <= wrapped_next;
        end
    end

    // Positions below the tail, or all once the tail has wrapped, are written.
    assign head_written = wrapped_reg || (head_reg < tail_reg);
    assign head_slot    = head_written ? rd_reg : head_reg;
    assign empty        = (count_reg == '0);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(SLOTS))
        else $error("free count exceeds the number of slots");

    a_ring_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        ((CW+1)'(head_reg) + (CW+1)'(count_reg) == (CW+1)'(tail_reg)) ||
        ((CW+1)'(head_reg) + (CW+1)'(count_reg) ==
         (CW+1)'(tail_reg) + (CW+1)'(SLOTS)))
        else $error("free list head, count and tail disagree");

    a_no_take_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |-> !empty)
        else $error("slot taken from an empty free list");
`endif

endmodule

@@ hw/rtl/sbms_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbms_ctrl: operation sequencer and stack top pointers
// Accepts one beat, issues the memory reads, then checks and commits the
// operation once the result register is free, and loads the result register.
// ----------------------------------------------------------------------------
module sbms_ctrl #(
    parameter int NUM_STACKS = 3,
    parameter int SLOTS      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  sbms_pkg::in_beat_t            s_payload,
    output logic                          m_valid,
    input  logic                          m_ready,
    output sbms_pkg::out_beat_t           m_payload,
    output logic                          rd_en,
    output logic [$clog2(SLOTS)-1:0]      node_rd_addr,
    output logic                          node_wr_en,
    output logic [$clog2(SLOTS)-1:0]      node_wr_addr,
    output logic [DATA_WIDTH-1:0]         node_wr_value,
    output logic [$clog2(SLOTS+1)-1:0]    node_wr_link,
    input  logic [DATA_WIDTH-1:0]         node_rd_value,
    input  logic [$clog2(SLOTS+1)-1:0]    node_rd_link,
    output sbms_pkg::fifo_cmd_t           fifo_cmd,
    output logic [$clog2(SLOTS)-1:0]      fifo_give_slot,
    input  logic [$clog2(SLOTS)-1:0]      fifo_head_slot,
    input  logic                          fifo_empty
);

    localparam int AW = $clog2(SLOTS);
    localparam int PW = $clog2(SLOTS + 1);
    localparam logic [PW-1:0] NULL_LINK = PW'(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    sbms_pkg::in_beat_t      req_reg;
    logic [PW-1:0]           top_reg  [NUM_STACKS];
    logic [PW-1:0]           top_next [NUM_STACKS];
    logic                    m_valid_reg, m_valid_next;
    sbms_pkg::out_beat_t     m_payload_reg, m_payload_next;
    logic                    s_accept;
    logic [PW-1:0]           in_top;
    logic [PW-1:0]           req_top;
    logic                    sel_valid;
    logic                    push_ok;
    logic                    pop_ok;
    logic                    commit;
    logic [63:0]             push_wide;
    logic [63:0]             pop_wide;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;

    // Top of the stack addressed by the incoming beat and by the held beat.
    always_comb begin
        in_top  = NULL_LINK;
        req_top = NULL_LINK;
        for (int i = 0; i < NUM_STACKS; i++) begin
            if (32'(s_payload.stack_select) == i) begin
                in_top = top_reg[i];
            end
            if (32'(req_reg.stack_select) == i) begin
                req_top = top_reg[i];
            end
        end
    end

    // Reads are issued on accept; results arrive for the execute cycle.
    assign rd_en        = s_accept;
    assign node_rd_addr = in_top[AW-1:0];

    // Checks on the held beat.
    assign sel_valid = (32'(req_reg.stack_select) < NUM_STACKS);
    assign push_ok   = (req_reg.kind == sbms_pkg::KIND_PUSH) && sel_valid && !fifo_empty;
    assign pop_ok    = (req_reg.kind == sbms_pkg::KIND_POP) && sel_valid &&
                       (req_top != NULL_LINK);
    assign commit    = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);

    // Node and free-list updates.
    assign push_wide      = 64'(req_reg.push_value);
    assign pop_wide       = 64'(node_rd_value);
    assign node_wr_en     = commit && push_ok;
    assign node_wr_addr   = fifo_head_slot;
    assign node_wr_value  = push_wide[DATA_WIDTH-1:0];
    assign node_wr_link   = req_top;
    assign fifo_cmd.take  = commit && push_ok;
    assign fifo_cmd.give  = commit && pop_ok;
    assign fifo_give_slot = req_top[AW-1:0];

    // Top pointer updates.
    always_comb begin
        for (int i = 0; i < NUM_STACKS; i++) begin
            top_next[i] = top_reg[i];
            if (commit && (32'(req_reg.stack_select) == i)) begin
                if (push_ok) begin
                    top_next[i] = PW'(fifo_head_slot);
                end else if (pop_ok) begin
                    top_next[i] = node_rd_link;
                end
            end
        end
    end

    // Result beat.
    always_comb begin
        m_payload_next = m_payload_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        if (commit) begin
            m_valid_next             = 1'b1;
            m_payload_next.pop_value = pop_ok ? pop_wide[31:0] : '0;
            if (req_reg.kind == sbms_pkg::KIND_PUSH) begin
                m_payload_next.status = push_ok ? sbms_pkg::STATUS_DONE
                                                : sbms_pkg::STATUS_FULL;
            end else begin
                m_payload_next.status = pop_ok ? sbms_pkg::STATUS_DONE
                                               : sbms_pkg::STATUS_EMPTY;
            end
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_STACKS; i++) begin
                top_reg[i] <= NULL_LINK;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < NUM_STACKS; i++) begin
                top_reg[i] <= top_next[i];
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg <= s_payload;
        end
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == S_EXEC))
        else $error("accepted beat did not enter the execute cycle");

    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result raised outside an execute cycle");

    a_one_update: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fifo_cmd.take && fifo_cmd.give))
        else $error("push and pop committed in the same cycle");
`endif

endmodule

@@ hw/rtl/shared_buffer_multi_stack_top.sv @@
// ----------------------------------------------------------------------------
// shared_buffer_multi_stack_top: several stacks in one node buffer
// A beat is accepted in the idle state, which starts the registered read of
// the node and free-list memories; the execute state then commits the
// operation and loads the result register. No beat is accepted before the commit.
// A result that waits on m_ready holds the commit cycle until it is taken.
// Reset is synchronous and active low: all stacks empty, free list in slot
// order; there is no clearing pass, the free list uses a fill mark instead.
// ----------------------------------------------------------------------------
module shared_buffer_multi_stack_top #(
    parameter int NUM_STACKS = 3,
    parameter int SLOTS      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sbms_pkg::in_beat_t   s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sbms_pkg::out_beat_t  m_payload
);

    localparam int AW = $clog2(SLOTS);
    localparam int PW = $clog2(SLOTS + 1);

    logic                  rd_en;
    logic [AW-1:0]         node_rd_addr;
    logic                  node_wr_en;
    logic [AW-1:0]         node_wr_addr;
    logic [DATA_WIDTH-1:0] node_wr_value;
    logic [PW-1:0]         node_wr_link;
    logic [DATA_WIDTH-1:0] node_rd_value;
    logic [PW-1:0]         node_rd_link;
    sbms_pkg::fifo_cmd_t   fifo_cmd;
    logic [AW-1:0]         fifo_give_slot;
    logic [AW-1:0]         fifo_head_slot;
    logic                  fifo_empty;

    // Sequencer and top pointers.
    sbms_ctrl #(
        .NUM_STACKS (NUM_STACKS),
        .SLOTS      (SLOTS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload      (m_payload),
        .rd_en          (rd_en),
        .node_rd_addr   (node_rd_addr),
        .node_wr_en     (node_wr_en),
        .node_wr_addr   (node_wr_addr),
        .node_wr_value  (node_wr_value),
        .node_wr_link   (node_wr_link),
        .node_rd_value  (node_rd_value),
        .node_rd_link   (node_rd_link),
        .fifo_cmd       (fifo_cmd),
        .fifo_give_slot (fifo_give_slot),
        .fifo_head_slot (fifo_head_slot),
        .fifo_empty     (fifo_empty)
    );

    // Shared node buffer.
    sbms_node_mem #(
        .SLOTS      (SLOTS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_node_mem (
        .aclk     (aclk),
        .rd_en    (rd_en),
        .rd_addr  (node_rd_addr),
        .wr_en    (node_wr_en),
        .wr_addr  (node_wr_addr),
        .wr_value (node_wr_value),
        .wr_link  (node_wr_link),
        .rd_value (node_rd_value),
        .rd_link  (node_rd_link)
    );

    // Free slot list.
    sbms_free_fifo #(
        .SLOTS (SLOTS)
    ) u_free_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (rd_en),
        .cmd       (fifo_cmd),
        .give_slot (fifo_give_slot),
        .head_slot (fifo_head_slot),
        .empty     (fifo_empty)
    );

endmodule
